[hw/rtl/imu_pkt_pkg.sv]
// Shared constants and codes for the IMU serial packet parser.
package imu_pkt_pkg;

   localparam int unsigned PKT_LEN       = 11;
   localparam int unsigned POS_W         = 4;
   localparam int unsigned PAYLOAD_BYTES = 8;
   localparam int unsigned PAYLOAD_IDX_W = 3;

   localparam logic [POS_W-1:0] POS_HEADER   = 4'd0;
   localparam logic [POS_W-1:0] POS_TYPE     = 4'd1;
   localparam logic [POS_W-1:0] POS_FIRST_PL = 4'd2;
   localparam logic [POS_W-1:0] POS_CHECKSUM = 4'd10;
   localparam logic [POS_W-1:0] POS_LIMIT    = 4'd11;

   localparam logic [7:0] PKT_HEADER = 8'h55;
   localparam logic [7:0] TYPE_ACCEL = 8'h51;
   localparam logic [7:0] TYPE_GYRO  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;

   typedef enum logic [1:0] {
      KIND_ACCEL = 2'd0,
      KIND_GYRO  = 2'd1,
      KIND_ANGLE = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_HDR   = 2'd1,
      STATUS_BAD_CKSUM = 2'd2,
      STATUS_RSVD      = 2'd3
   } status_type;

   function automatic kind_type kind_of(input logic [7:0] t);
      kind_type k;
      case (t)
         TYPE_ACCEL: k = KIND_ACCEL;
         TYPE_GYRO:  k = KIND_GYRO;
         TYPE_ANGLE: k = KIND_ANGLE;
         default:    k = KIND_OTHER;
      endcase
      return k;
   endfunction

endpackage

[hw/rtl/imu_pkt_ifs.sv]
// Request and response channel interfaces for the IMU packet parser.
interface imu_pkt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       burst_start;

   modport source (output valid, output rx_byte, output burst_start, input ready);
   modport sink   (input valid, input rx_byte, input burst_start, output ready);
endinterface

interface imu_pkt_rsp_if
   import imu_pkt_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [1:0]         packet_kind;
   logic [1:0]         status;
   logic [7:0]         type_code;
   logic signed [15:0] word_a;
   logic signed [15:0] word_b;
   logic signed [15:0] word_c;
   logic signed [15:0] word_d;

   modport source (output valid, output packet_kind, output status, output type_code,
                   output word_a, output word_b, output word_c, output word_d,
                   input ready);
   modport sink   (input valid, input packet_kind, input status, input type_code,
                   input word_a, input word_b, input word_c, input word_d,
                   output ready);
endinterface

[hw/rtl/imu_packet_parser_sum_checksum.sv]
// IMU serial packet parser: 11-byte frames with an 8-bit additive checksum.
//
// req_chan carries one received serial byte per request, with burst_start
// marking the first byte of a new burst (it realigns the packet at byte 0 and
// drops any partial packet). rsp_chan carries one response per completed
// packet: kind, status (accepted, bad header, checksum mismatch), raw type
// byte and four little-endian signed words from bytes 2..9.
//
// Throughput is one request per cycle. A response appears in the output
// register in the cycle after the checksum byte (byte 10) is accepted and holds
// until taken. While a response waits, requests for bytes 0..9 are still
// accepted; only a request at the checksum position stalls until the output
// register is taken or emptied in the same cycle.
//
// Reset (synchronous, active high) clears the byte position, running sum,
// header flag, type byte and the response valid. Payload bytes are not reset;
// each is written before it is read.
module imu_packet_parser_sum_checksum
   import imu_pkt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   imu_pkt_req_if.sink    req_chan,
   imu_pkt_rsp_if.source  rsp_chan
);

   logic [POS_W-1:0] byte_position_ff, byte_position_in;
   logic [7:0]       running_sum_ff, running_sum_in;
   logic             header_good_ff, header_good_in;
   logic [7:0]       kind_byte_ff, kind_byte_in;
   logic [7:0]       payload_ff [PAYLOAD_BYTES];

   logic             rsp_valid_ff, rsp_valid_in;
   kind_type         rsp_kind_ff;
   status_type       rsp_status_ff, status_calc;
   logic [7:0]       rsp_type_ff;
   logic [15:0]      rsp_word_ff [4];

   logic             req_fire;
   logic             emit;
   logic             pl_write;
   logic [POS_W-1:0] pos_eff;
   logic [POS_W-1:0] pl_offset;
   logic [7:0]       sum_add;

   // only the checksum byte needs the output register free
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready || (byte_position_ff != POS_CHECKSUM);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign pos_eff   = (req_chan.burst_start || byte_position_ff >= POS_LIMIT)
                      ? POS_HEADER : byte_position_ff;
   assign sum_add   = running_sum_ff + req_chan.rx_byte;
   assign pl_offset = pos_eff - POS_FIRST_PL;

   always_comb begin
      byte_position_in = byte_position_ff;
      running_sum_in   = running_sum_ff;
      header_good_in   = header_good_ff;
      kind_byte_in     = kind_byte_ff;
      emit             = 1'b0;
      pl_write         = 1'b0;
      if (req_fire) begin
         case (pos_eff)
            POS_HEADER: begin
               header_good_in   = (req_chan.rx_byte == PKT_HEADER);
               running_sum_in   = req_chan.rx_byte;
               byte_position_in = POS_TYPE;
            end
            POS_TYPE: begin
               kind_byte_in     = req_chan.rx_byte;
               running_sum_in   = sum_add;
               byte_position_in = POS_FIRST_PL;
            end
            POS_CHECKSUM: begin
               emit             = 1'b1;
               running_sum_in   = 8'd0;
               byte_position_in = POS_HEADER;
            end
            default: begin
               pl_write         = 1'b1;
               running_sum_in   = sum_add;
               byte_position_in = pos_eff + 4'd1;
            end
         endcase
      end
   end

   always_comb begin
      if (!header_good_ff)
         status_calc = STATUS_BAD_HDR;
      else if (running_sum_ff != req_chan.rx_byte)
         status_calc = STATUS_BAD_CKSUM;
      else
         status_calc = STATUS_OK;
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= POS_HEADER;
         running_sum_ff   <= 8'd0;
         header_good_ff   <= 1'b0;
         kind_byte_ff     <= 8'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         byte_position_ff <= byte_position_in;
         running_sum_ff   <= running_sum_in;
         header_good_ff   <= header_good_in;
         kind_byte_ff     <= kind_byte_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pl_write) begin
         payload_ff[pl_offset[PAYLOAD_IDX_W-1:0]] <= req_chan.rx_byte;
      end
      if (emit) begin
         rsp_kind_ff   <= kind_of(kind_byte_ff);
         rsp_status_ff <= status_calc;
         rsp_type_ff   <= kind_byte_ff;
         for (int i = 0; i < 4; i++) begin
            rsp_word_ff[i] <= {payload_ff[2*i+1], payload_ff[2*i]};
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.packet_kind = rsp_kind_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.type_code   = rsp_type_ff;
   assign rsp_chan.word_a      = signed'(rsp_word_ff[0]);
   assign rsp_chan.word_b      = signed'(rsp_word_ff[1]);
   assign rsp_chan.word_c      = signed'(rsp_word_ff[2]);
   assign rsp_chan.word_d      = signed'(rsp_word_ff[3]);

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the IMU serial packet parser: random byte stream, scoreboarded responses.
module tb_top;
   import imu_pkt_pkg::*;

   localparam int CYCLE_LIMIT   = 100000;
   localparam int RANDOM_BYTES  = 800;
   localparam int REPORT_LIMIT  = 10;
   localparam int IDLE_PCT      = 29;
   localparam int DRAIN_CYCLES  = 8;

   typedef struct packed {
      logic       start;
      logic [7:0] data;
   } rx_item_type;

   typedef struct packed {
      kind_type           kind;
      status_type         status;
      logic [7:0]         type_code;
      logic signed [15:0] word_a;
      logic signed [15:0] word_b;
      logic signed [15:0] word_c;
      logic signed [15:0] word_d;
   } frame_type;

   logic clock;
   logic reset;

   imu_pkt_req_if req_chan ();
   imu_pkt_rsp_if rsp_chan ();

   imu_packet_parser_sum_checksum dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rx_item_type byte_queue[$];
   frame_type   frames_due[$];
   int          bytes_queued = 0;
   int          bytes_sent   = 0;
   int          frames_seen  = 0;
   int          mismatches   = 0;
   int          cycle_count  = 0;
   logic        calm;

   // parser shadow state
   logic [3:0] slot      = POS_HEADER;
   logic [7:0] sum_acc   = '0;
   logic       hdr_seen  = 1'b0;
   logic [7:0] type_seen = '0;
   logic [7:0] body [PAYLOAD_BYTES];

   // one stretch of the run where neither side idles
   assign calm = (bytes_sent >= 300) && (bytes_sent < 450);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.rx_byte     = '0;
      req_chan.burst_start = 1'b0;
      rsp_chan.ready       = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic track_byte(input logic [7:0] data, input logic start);
      logic [3:0] at;
      frame_type  f;
      at = (start || slot >= POS_LIMIT) ? POS_HEADER : slot;
      if (at == POS_HEADER) begin
         hdr_seen = (data == PKT_HEADER);
         sum_acc  = data;
         slot     = POS_TYPE;
      end else if (at == POS_TYPE) begin
         type_seen = data;
         sum_acc   = sum_acc + data;
         slot      = POS_FIRST_PL;
      end else if (at < POS_CHECKSUM) begin
         body[3'(at - POS_FIRST_PL)] = data;
         sum_acc = sum_acc + data;
         slot    = at + 4'd1;
      end else begin
         case (type_seen)
            TYPE_ACCEL: f.kind = KIND_ACCEL;
            TYPE_GYRO:  f.kind = KIND_GYRO;
            TYPE_ANGLE: f.kind = KIND_ANGLE;
            default:    f.kind = KIND_OTHER;
         endcase
         // a bad header wins over a bad checksum
         if (!hdr_seen)
            f.status = STATUS_BAD_HDR;
         else if (sum_acc != data)
            f.status = STATUS_BAD_CKSUM;
         else
            f.status = STATUS_OK;
         f.type_code = type_seen;
         f.word_a    = {body[1], body[0]};
         f.word_b    = {body[3], body[2]};
         f.word_c    = {body[5], body[4]};
         f.word_d    = {body[7], body[6]};
         frames_due.push_back(f);
         slot    = POS_HEADER;
         sum_acc = '0;
      end
   endtask

   function automatic logic [7:0] frame_sum(input logic [7:0] frame [PKT_LEN]);
      logic [7:0] s;
      s = '0;
      for (int i = 0; i < PKT_LEN - 1; i++)
         s = s + frame[i];
      return s;
   endfunction

   function automatic logic [7:0] payload_byte();
      logic [7:0] corner [4];
      corner = '{8'h00, 8'h80, 8'h7F, 8'hFF};
      if ($urandom_range(7) == 0)
         return corner[2'($urandom_range(3))];
      return 8'($urandom_range(255));
   endfunction

   task automatic send_frame(input logic [7:0] frame [PKT_LEN], input int len,
                             input bit fresh);
      rx_item_type it;
      for (int i = 0; i < len; i++) begin
         it.data  = frame[i];
         it.start = fresh && (i == 0);
         byte_queue.push_back(it);
         bytes_queued++;
      end
   endtask

   task automatic wait_all_done();
      while (byte_queue.size() != 0 || req_chan.valid || frames_due.size() != 0)
         @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      rx_item_type nxt;
      bit          fire;
      bit          idle_now;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         fire = req_chan.valid && req_chan.ready;
         if (fire) begin
            track_byte(req_chan.rx_byte, req_chan.burst_start);
            bytes_sent++;
         end
         if (!req_chan.valid || fire) begin
            idle_now = !calm && ($urandom_range(99) < IDLE_PCT);
            if (byte_queue.size() != 0 && !idle_now) begin
               nxt = byte_queue.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.rx_byte     <= nxt.data;
               req_chan.burst_start <= nxt.start;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : watch_rsp
      frame_type want;
      frame_type got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind      = kind_type'(rsp_chan.packet_kind);
            got.status    = status_type'(rsp_chan.status);
            got.type_code = rsp_chan.type_code;
            got.word_a    = rsp_chan.word_a;
            got.word_b    = rsp_chan.word_b;
            got.word_c    = rsp_chan.word_c;
            got.word_d    = rsp_chan.word_d;
            if (frames_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("[%0t] unexpected response: kind %0d status %0d type %h",
                           $realtime, got.kind, got.status, got.type_code);
            end else begin
               want = frames_due.pop_front();
               if (got.kind !== want.kind || got.status !== want.status ||
                   got.type_code !== want.type_code || got.word_a !== want.word_a ||
                   got.word_b !== want.word_b || got.word_c !== want.word_c ||
                   got.word_d !== want.word_d) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("[%0t] response %0d mismatch", $realtime, frames_seen);
                     $display("   expected kind %0d status %0d type %h words %0d %0d %0d %0d",
                              want.kind, want.status, want.type_code,
                              want.word_a, want.word_b, want.word_c, want.word_d);
                     $display("   actual   kind %0d status %0d type %h words %0d %0d %0d %0d",
                              got.kind, got.status, got.type_code,
                              got.word_a, got.word_b, got.word_c, got.word_d);
                  end
               end
            end
            frames_seen++;
         end
         rsp_chan.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** imu_packet_parser_sum_checksum: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      logic [7:0] frame [PKT_LEN];
      int         len;
      int         roll;
      bit         fresh;
      bit         need_align;

      // good accel packet with the word extremes
      frame = '{PKT_HEADER, TYPE_ACCEL, 8'h00, 8'h80, 8'hFF, 8'h7F,
                8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
      frame[PKT_LEN-1] = frame_sum(frame);
      send_frame(frame, PKT_LEN, 1'b1);
      // partial packet cut off by a new burst
      frame = '{PKT_HEADER, TYPE_GYRO, 8'h12, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_frame(frame, 3, 1'b1);
      // bad header and bad checksum together, unknown type
      frame = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
      frame[PKT_LEN-1] = frame_sum(frame) + 8'd1;
      send_frame(frame, PKT_LEN, 1'b1);

      // sender holds off until the parser has drained
      wait_all_done();

      need_align = 1'b0;
      while (bytes_queued < RANDOM_BYTES + 25) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            // line noise, then realign on the next packet
            len = $urandom_range(1, 5);
            for (int i = 0; i < PKT_LEN; i++)
               frame[i] = 8'($urandom_range(255));
            send_frame(frame, len, 1'($urandom_range(1)));
            need_align = 1'b1;
         end else begin
            frame[0] = ($urandom_range(99) < 90) ? PKT_HEADER : 8'($urandom_range(255));
            case ($urandom_range(4))
               0:       frame[1] = TYPE_ACCEL;
               1:       frame[1] = TYPE_GYRO;
               2:       frame[1] = TYPE_ANGLE;
               default: frame[1] = 8'($urandom_range(255));
            endcase
            for (int i = 2; i < PKT_LEN - 1; i++)
               frame[i] = payload_byte();
            frame[PKT_LEN-1] = frame_sum(frame);
            if ($urandom_range(99) < 20)
               frame[PKT_LEN-1] = frame[PKT_LEN-1] + 8'($urandom_range(1, 255));
            len   = ($urandom_range(99) < 8) ? $urandom_range(1, PKT_LEN - 1) : PKT_LEN;
            fresh = need_align || $urandom_range(1);
            send_frame(frame, len, fresh);
            need_align = (len != PKT_LEN);
         end
      end

      wait_all_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && frames_due.size() == 0)
         $display("** imu_packet_parser_sum_checksum: PASSED **");
      else
         $display("** imu_packet_parser_sum_checksum: FAILED **");
      $finish;
   end

endmodule
